// File: sv/pvm_pkg.sv
// Shared constants and types for the PCM voice mixer.
`default_nettype none
package pvm_pkg;
  localparam int VOICES      = 8;
  localparam int SOUNDS      = 16;
  localparam int STORE_WORDS = 65536;

  localparam int ADDR_W  = $clog2(STORE_WORDS);
  localparam int SND_W   = (SOUNDS > 1) ? $clog2(SOUNDS) : 1;
  localparam int VOICE_W = $clog2(VOICES);
  localparam int CNT_W   = $clog2(VOICES + 1);
  localparam int SUM_W   = 16 + $clog2(VOICES) + 1;
  localparam int CUR_W   = 17;

  localparam logic [1:0] MODE_WR_SAMPLE = 2'd0;
  localparam logic [1:0] MODE_WR_SOUND  = 2'd1;
  localparam logic [1:0] MODE_PLAY      = 2'd2;
  localparam logic [1:0] MODE_TICK      = 2'd3;

  typedef struct packed {
    logic [15:0]      start;
    logic [CUR_W-1:0] limit;
    logic             stereo;
    logic             loop_en;
    logic             present;
  } snd_desc_t;
endpackage
`default_nettype wire

// File: sv/pvm_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module pvm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: sv/pvm_div.sv
// Restoring divider, one quotient bit per cycle, for the mix averages.
`default_nettype none
module pvm_div
  import pvm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [SUM_W-1:0] num,
  input  wire logic [CNT_W-1:0] den,
  output logic      [SUM_W-1:0] quo,
  output logic                  done
);
  localparam int STEP_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0]  quo_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  den_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;
  logic [CNT_W:0]    trial;

  assign trial = {rem_r, quo_r[SUM_W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        if (step_r == STEP_W'(SUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        step_r <= step_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_r <= CNT_W'(trial - {1'b0, den_r});
        quo_r <= {quo_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_r <= trial[CNT_W-1:0];
        quo_r <= {quo_r[SUM_W-2:0], 1'b0};
      end
    end
  end

  assign quo  = quo_r;
  assign done = done_r;
endmodule
`default_nettype wire

// File: sv/pcm_voice_mixer.sv
// Top level of the averaging PCM voice mixer.
// Each request is one of: write a sample word into the sample store, write a
// sound descriptor, start a sound on the lowest free voice (the last voice is
// reserved and never started; a start with no free voice or an empty slot is
// dropped), or tick one stereo frame. Only a tick produces an output request,
// carrying left and right averages (sum divided by contributor count,
// truncated toward zero; the bare sum when the count is 0 or 1). Sample,
// descriptor and play requests are taken only while no tick is in progress. A tick walks the voices one
// at a time through the single read port of the sample store: an idle or
// exhausted voice visits S_VOICE only, a voice adding one word S_VOICE and
// S_LEFT, a stereo voice adding two words S_VOICE, S_LEFT and S_RIGHT; then two
// parallel bit-serial dividers work through SUM_W (20 for 8 voices) quotient
// bits, framed by the S_DIV, S_WAIT and S_OUT control states. The reserved last
// voice is never active and always visits S_VOICE only. The sample store has no reset; reading a word
// never written returns whatever the memory holds.
`default_nettype none
module pcm_voice_mixer
  import pvm_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_mode,
  input  wire logic [15:0]        in_address,
  input  wire logic signed [15:0] in_sample_value,
  input  wire logic [3:0]         in_sound_index,
  input  wire logic [15:0]        in_sound_start,
  input  wire logic [16:0]        in_sound_length,
  input  wire logic               in_sound_stereo,
  input  wire logic               in_sound_loop,
  input  wire logic               in_sound_present,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      out_left_sample,
  output logic signed [15:0]      out_right_sample
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_VOICE = 3'd1;
  localparam logic [2:0] S_LEFT  = 3'd2;
  localparam logic [2:0] S_RIGHT = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_WAIT  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0] state_r, state_nxt;

  // Descriptor table and voice state in flops, cleared at reset.
  snd_desc_t        snd_r    [SOUNDS];
  logic [VOICES-1:0] act_r;
  logic [SND_W-1:0] slot_r   [VOICES];
  logic [CUR_W-1:0] cur_r    [VOICES];

  logic [VOICE_W-1:0] v_r;
  logic signed [SUM_W-1:0] lsum_r, rsum_r;
  logic [CNT_W-1:0] lnum_r, rnum_r;
  logic out_valid_r;
  logic signed [15:0] left_r, right_r;

  logic accept;
  logic idx_ok;
  logic [SND_W-1:0] idx;
  snd_desc_t desc;
  logic [CUR_W-1:0] cur;
  logic [CUR_W:0]   cur1, cur2;
  logic [ADDR_W-1:0] raddr;
  logic [15:0] rdata;
  logic signed [SUM_W-1:0] word;
  logic last_voice;

  logic free_found;
  logic [VOICE_W-1:0] free_v;

  logic lneg, rneg;
  logic [SUM_W-1:0] lmag, rmag, lquo, rquo;
  logic div_start, ldone, rdone;
  logic signed [SUM_W-1:0] lres, rres;

  assign accept = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign idx = SND_W'(in_sound_index);
  assign idx_ok = 32'(in_sound_index) < SOUNDS;

  assign desc = snd_r[slot_r[v_r]];
  assign cur  = cur_r[v_r];
  assign cur1 = {1'b0, cur} + 1'b1;
  assign cur2 = {1'b0, cur} + 2'd2;
  assign word = SUM_W'(signed'(rdata));
  assign last_voice = (v_r == VOICE_W'(VOICES - 1));

  // Read the left word at start + cursor, the right word one further on.
  always_comb begin
    if (state_r == S_LEFT) begin
      raddr = ADDR_W'({1'b0, desc.start} + cur1);
    end else begin
      raddr = ADDR_W'({1'b0, desc.start} + {1'b0, cur});
    end
  end

  pvm_ram #(.WIDTH(16), .DEPTH(STORE_WORDS)) u_store (
    .clk   (clk),
    .we    (accept && (in_mode == MODE_WR_SAMPLE)),
    .waddr (ADDR_W'(in_address)),
    .wdata (in_sample_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Lowest idle voice, excluding the reserved last one.
  always_comb begin
    free_found = 1'b0;
    free_v = '0;
    for (int i = 0; i < VOICES - 1; i++) begin
      if (!act_r[i] && !free_found) begin
        free_found = 1'b1;
        free_v = VOICE_W'(i);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && (in_mode == MODE_TICK)) begin
          state_nxt = S_VOICE;
        end
      end
      S_VOICE: begin
        if (act_r[v_r] && ({1'b0, cur} < {1'b0, desc.limit})) begin
          state_nxt = S_LEFT;
        end else if (last_voice) begin
          state_nxt = S_DIV;
        end
      end
      S_LEFT: begin
        if (desc.stereo && (cur1 < {1'b0, desc.limit})) begin
          state_nxt = S_RIGHT;
        end else begin
          state_nxt = last_voice ? S_DIV : S_VOICE;
        end
      end
      S_RIGHT: state_nxt = last_voice ? S_DIV : S_VOICE;
      S_DIV:   state_nxt = S_WAIT;
      S_WAIT:  if (ldone) state_nxt = S_OUT;
      S_OUT:   if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Descriptor table and voice state.
  always_ff @(posedge clk) begin
    logic [CUR_W:0] cn;
    cn = '0;
    if (!rst_n) begin
      for (int i = 0; i < SOUNDS; i++) begin
        snd_r[i] <= '0;
      end
      act_r <= '0;
      for (int i = 0; i < VOICES; i++) begin
        slot_r[i] <= '0;
        cur_r[i]  <= '0;
      end
    end else begin
      if (accept && (in_mode == MODE_WR_SOUND) && idx_ok) begin
        snd_r[idx] <= '{start: in_sound_start, limit: in_sound_length,
                        stereo: in_sound_stereo, loop_en: in_sound_loop,
                        present: in_sound_present};
      end
      if (accept && (in_mode == MODE_PLAY) && idx_ok && snd_r[idx].present
          && free_found) begin
        act_r[free_v]  <= 1'b1;
        slot_r[free_v] <= idx;
        cur_r[free_v]  <= '0;
      end
      // Advance the cursor; rewind at the limit and stop unless looping.
      if (state_r == S_LEFT) begin
        if (desc.stereo && (cur1 < {1'b0, desc.limit})) begin
          cn = cur2;
        end else begin
          cn = cur1;
        end
        if (cn >= {1'b0, desc.limit}) begin
          cur_r[v_r] <= '0;
          if (!desc.loop_en) begin
            act_r[v_r] <= 1'b0;
          end
        end else begin
          cur_r[v_r] <= CUR_W'(cn);
        end
      end
    end
  end

  // Step the voice index over the voice walk; below, accumulate sums and contributor counts.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (state_r == S_IDLE) begin
        v_r <= '0;
      end else if (((state_r == S_VOICE) && (state_nxt != S_LEFT)) ||
                   ((state_r == S_LEFT) && (state_nxt != S_RIGHT)) ||
                   (state_r == S_RIGHT)) begin
        v_r <= v_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE) begin
      lsum_r <= '0;
      rsum_r <= '0;
      lnum_r <= '0;
      rnum_r <= '0;
    end else if (state_r == S_LEFT) begin
      lsum_r <= lsum_r + word;
      lnum_r <= lnum_r + 1'b1;
      if (!desc.stereo) begin
        rsum_r <= rsum_r + word;
        rnum_r <= rnum_r + 1'b1;
      end
    end else if (state_r == S_RIGHT) begin
      rsum_r <= rsum_r + word;
      rnum_r <= rnum_r + 1'b1;
    end
  end

  // Divide magnitudes; restore the sign afterwards.
  assign lneg = lsum_r[SUM_W-1];
  assign rneg = rsum_r[SUM_W-1];
  assign lmag = lneg ? SUM_W'(-lsum_r) : SUM_W'(lsum_r);
  assign rmag = rneg ? SUM_W'(-rsum_r) : SUM_W'(rsum_r);
  assign div_start = (state_r == S_DIV);

  pvm_div u_ldiv (
    .clk (clk), .rst_n (rst_n), .start (div_start),
    .num (lmag), .den (lnum_r), .quo (lquo), .done (ldone)
  );

  pvm_div u_rdiv (
    .clk (clk), .rst_n (rst_n), .start (div_start),
    .num (rmag), .den (rnum_r), .quo (rquo), .done (rdone)
  );

  always_comb begin
    if (lnum_r > CNT_W'(1)) begin
      lres = lneg ? -signed'(lquo) : signed'(lquo);
    end else begin
      lres = lsum_r;
    end
    if (rnum_r > CNT_W'(1)) begin
      rres = rneg ? -signed'(rquo) : signed'(rquo);
    end else begin
      rres = rsum_r;
    end
  end

  // Hold the results until the output request is free, then post them.
  always_ff @(posedge clk) begin
    if (state_r == S_WAIT && (ldone || rdone)) begin
      left_r  <= lres[15:0];
      right_r <= rres[15:0];
    end else if (state_r == S_OUT && (!out_valid_r || !out_stall)) begin
      out_left_sample  <= left_r;
      out_right_sample <= right_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_OUT && (!out_valid_r || !out_stall)) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
endmodule
`default_nettype wire

// File: sim/tb_pcm_voice_mixer.sv
// Testbench for the PCM voice mixer: directed and random requests checked against a predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb_pcm_voice_mixer;
  import pvm_pkg::*;

  typedef struct {
    logic [1:0]  mode;
    logic [15:0] address;
    logic [15:0] sample_value;
    logic [3:0]  sound_index;
    logic [15:0] sound_start;
    logic [16:0] sound_length;
    logic        sound_stereo;
    logic        sound_loop;
    logic        sound_present;
  } mix_req_t;

  typedef struct {
    logic [15:0] left;
    logic [15:0] right;
  } mix_frame_t;

  // Mirror of the mixer state; predicts one frame per tick request.
  class mix_scoreboard;
    logic [15:0] store [int];
    logic [15:0] snd_start [SOUNDS];
    logic [16:0] snd_limit [SOUNDS];
    bit          snd_stereo [SOUNDS];
    bit          snd_loop [SOUNDS];
    bit          snd_present [SOUNDS];
    bit          voice_on [VOICES];
    int          voice_slot [VOICES];
    int          voice_cur [VOICES];
    mix_frame_t  frames_due [$];
    int          errors;

    function new();
      errors = 0;
      foreach (snd_present[i]) begin
        snd_start[i] = '0; snd_limit[i] = '0;
        snd_stereo[i] = 0; snd_loop[i] = 0; snd_present[i] = 0;
      end
      foreach (voice_on[v]) begin
        voice_on[v] = 0; voice_slot[v] = 0; voice_cur[v] = 0;
      end
    endfunction

    function int word_at(int s, int c);
      logic [15:0] w;
      w = store[(s + c) % STORE_WORDS];
      return int'($signed(w));
    endfunction

    // Collect store addresses the next tick would read that were never written.
    function void unwritten_reads(ref int addrs [$]);
      int s, c, lim, a;
      addrs.delete();
      for (int v = 0; v < VOICES; v++) begin
        if (!voice_on[v]) continue;
        s = int'(snd_start[voice_slot[v]]);
        lim = int'(snd_limit[voice_slot[v]]);
        c = voice_cur[v];
        if (c >= lim) continue;
        a = (s + c) % STORE_WORDS;
        if (!store.exists(a)) addrs.push_back(a);
        if (snd_stereo[voice_slot[v]] && c + 1 < lim) begin
          a = (s + c + 1) % STORE_WORDS;
          if (!store.exists(a)) addrs.push_back(a);
        end
      end
    endfunction

    function void note_request(mix_req_t r);
      int lsum, rsum, lnum, rnum, sl, c, lim, res_l, res_r;
      mix_frame_t f;
      case (r.mode)
        MODE_WR_SAMPLE: store[int'(r.address)] = r.sample_value;
        MODE_WR_SOUND: begin
          snd_start[r.sound_index]   = r.sound_start;
          snd_limit[r.sound_index]   = r.sound_length;
          snd_stereo[r.sound_index]  = r.sound_stereo;
          snd_loop[r.sound_index]    = r.sound_loop;
          snd_present[r.sound_index] = r.sound_present;
        end
        MODE_PLAY: begin
          if (snd_present[r.sound_index]) begin
            // last voice stays reserved
            for (int v = 0; v < VOICES - 1; v++) begin
              if (!voice_on[v]) begin
                voice_on[v] = 1; voice_slot[v] = int'(r.sound_index); voice_cur[v] = 0;
                break;
              end
            end
          end
        end
        default: begin
          lsum = 0; rsum = 0; lnum = 0; rnum = 0;
          for (int v = 0; v < VOICES; v++) begin
            if (!voice_on[v]) continue;
            sl = voice_slot[v];
            lim = int'(snd_limit[sl]);
            c = voice_cur[v];
            if (c >= lim) continue;
            lsum += word_at(int'(snd_start[sl]), c);
            lnum++;
            c++;
            if (!snd_stereo[sl]) begin
              rsum += word_at(int'(snd_start[sl]), c - 1);
              rnum++;
            end else if (c < lim) begin
              rsum += word_at(int'(snd_start[sl]), c);
              rnum++;
              c++;
            end
            if (c >= lim) begin
              c = 0;
              if (!snd_loop[sl]) voice_on[v] = 0;
            end
            voice_cur[v] = c;
          end
          res_l = (lnum > 1) ? lsum / lnum : lsum;
          res_r = (rnum > 1) ? rsum / rnum : rsum;
          f.left = res_l[15:0];
          f.right = res_r[15:0];
          frames_due.push_back(f);
        end
      endcase
    endfunction

    function void check_mix(logic [15:0] l, logic [15:0] r);
      mix_frame_t f;
      if (frames_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected frame L=%0d R=%0d", $signed(l), $signed(r));
        return;
      end
      f = frames_due.pop_front();
      if (l !== f.left || r !== f.right) begin
        errors++;
        if (errors <= 10)
          $display("frame mismatch: expected L=%0d R=%0d, got L=%0d R=%0d",
                   $signed(f.left), $signed(f.right), $signed(l), $signed(r));
      end
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 1000000;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_valid = 0;
  logic               in_stall;
  logic [1:0]         in_mode = MODE_WR_SAMPLE;
  logic [15:0]        in_address = '0;
  logic signed [15:0] in_sample_value = '0;
  logic [3:0]         in_sound_index = '0;
  logic [15:0]        in_sound_start = '0;
  logic [16:0]        in_sound_length = '0;
  logic               in_sound_stereo = 0;
  logic               in_sound_loop = 0;
  logic               in_sound_present = 0;
  logic               out_valid;
  logic               out_stall = 0;
  logic signed [15:0] out_left_sample;
  logic signed [15:0] out_right_sample;

  mix_scoreboard sb = new();
  int  cycles = 0;
  int  sent = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_off = 0;

  pcm_voice_mixer dut (.*);

  always #1 clk = ~clk;

  // Bail out if the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver: stall at random, or hold the output completely during a hold-off.
  always @(negedge clk)
    out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);

  // Check every frame the receiver accepts.
  always @(posedge clk)
    if (rst_n && out_valid && !out_stall) sb.check_mix(out_left_sample, out_right_sample);

  // Offer one request, idling first at random; return once it is accepted.
  task automatic push_request(mix_req_t r);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_mode <= r.mode;
    in_address <= r.address;
    in_sample_value <= r.sample_value;
    in_sound_index <= r.sound_index;
    in_sound_start <= r.sound_start;
    in_sound_length <= r.sound_length;
    in_sound_stereo <= r.sound_stereo;
    in_sound_loop <= r.sound_loop;
    in_sound_present <= r.sound_present;
    in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(r);
    sent++;
  endtask

  // Issue a request; ahead of a tick, fill any store word it would read unwritten.
  task automatic issue(mix_req_t r);
    int holes [$];
    mix_req_t w;
    if (r.mode == MODE_TICK) begin
      sb.unwritten_reads(holes);
      foreach (holes[i]) begin
        if (sb.store.exists(holes[i])) continue;
        w = '{default: '0};
        w.mode = MODE_WR_SAMPLE;
        w.address = 16'(holes[i]);
        w.sample_value = 16'($urandom);
        push_request(w);
      end
    end
    push_request(r);
  endtask

  task automatic write_word(int a, int val);
    mix_req_t r;
    r = '{default: '0};
    r.mode = MODE_WR_SAMPLE; r.address = 16'(a); r.sample_value = 16'(val);
    issue(r);
  endtask

  task automatic write_sound(int idx, int s, int len, bit st, bit lp, bit pr);
    mix_req_t r;
    r = '{default: '0};
    r.mode = MODE_WR_SOUND; r.sound_index = 4'(idx); r.sound_start = 16'(s);
    r.sound_length = 17'(len); r.sound_stereo = st; r.sound_loop = lp; r.sound_present = pr;
    issue(r);
  endtask

  task automatic play_or_tick(logic [1:0] m, int idx);
    mix_req_t r;
    r = '{default: '0};
    r.mode = m; r.sound_index = 4'(idx);
    issue(r);
  endtask

  // Random request: mostly short sounds near a few hot regions, with some noise.
  task automatic random_request();
    mix_req_t r;
    int pick, bases [4];
    bases = '{16'h0000, 16'h0100, 16'h1000, 16'hFFF0};
    r.mode = MODE_WR_SAMPLE;
    r.address = 16'($urandom);
    r.sample_value = 16'($urandom);
    r.sound_index = 4'($urandom);
    r.sound_start = 16'($urandom);
    r.sound_length = 17'($urandom_range(65536));
    r.sound_stereo = 1'($urandom);
    r.sound_loop = 1'($urandom);
    r.sound_present = ($urandom_range(9) != 0);
    pick = $urandom_range(99);
    if (pick < 20) begin
      r.mode = MODE_WR_SAMPLE;
      if ($urandom_range(9) != 0)
        r.address = 16'(bases[$urandom_range(3)] + $urandom_range(40));
    end else if (pick < 35) begin
      r.mode = MODE_WR_SOUND;
      if ($urandom_range(9) < 7)
        r.sound_start = 16'(bases[$urandom_range(3)] + $urandom_range(31));
      pick = $urandom_range(99);
      if (pick < 80) r.sound_length = 17'($urandom_range(24));
      else if (pick < 92) r.sound_length = 17'($urandom_range(25, 300));
      else if (pick < 96) r.sound_length = '0;
      else if (pick < 98) r.sound_length = 17'(65536);
      if ($urandom_range(3) != 0 && r.sound_length > 24) r.sound_loop = 0;
    end else if (pick < 55) begin
      r.mode = MODE_PLAY;
    end else begin
      r.mode = MODE_TICK;
    end
    issue(r);
  endtask

  initial begin
    int idle_cfg [4];
    int stall_cfg [4];
    int phase_end;
    idle_cfg = '{0, 74, 0, 33};
    stall_cfg = '{0, 0, 74, 33};
    repeat (11) @(negedge clk);
    rst_n <= 1;

    // Directed: extreme words, address wrap, empty tick, empty slot, limit zero,
    // odd stereo limit, full voice pool, descriptor rewritten mid-play.
    play_or_tick(MODE_TICK, 0);
    write_word(0, -32768);
    write_word(1, 32767);
    write_word(2, -1);
    write_word(3, 1);
    write_word(16'hFFFF, -7);
    write_sound(0, 0, 3, 1, 1, 1);
    write_sound(1, 16'hFFFF, 3, 0, 0, 1);
    write_sound(2, 0, 0, 0, 0, 1);
    write_sound(15, 0, 65536, 1, 1, 0);
    play_or_tick(MODE_PLAY, 15);
    play_or_tick(MODE_PLAY, 0);
    play_or_tick(MODE_PLAY, 1);
    play_or_tick(MODE_PLAY, 2);
    play_or_tick(MODE_TICK, 0);
    play_or_tick(MODE_TICK, 0);
    for (int i = 0; i < 5; i++) play_or_tick(MODE_PLAY, 0);
    play_or_tick(MODE_TICK, 0);
    write_sound(0, 16'hFFFE, 65536, 0, 1, 0);
    play_or_tick(MODE_TICK, 0);
    play_or_tick(MODE_TICK, 0);

    // Random phases with different idle patterns; the first one holds the
    // receiver off for a long stretch so the block backs up into its input.
    // Each phase counts every request it sends, fill writes included.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_cfg[ph];
      recv_stall_pct = stall_cfg[ph];
      if (ph == 0) begin
        fork
          begin
            repeat (50) @(posedge clk);
            hold_off = 1;
            repeat (600) @(posedge clk);
            hold_off = 0;
          end
        join_none
      end
      phase_end = sent + 410;
      while (sent < phase_end) random_request();
    end

    @(negedge clk);
    in_valid <= 0;
    while (sb.frames_due.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: pcm_voice_mixer.f
sv/pvm_pkg.sv
sv/pvm_ram.sv
sv/pvm_div.sv
sv/pcm_voice_mixer.sv
sim/tb_pcm_voice_mixer.sv
